// ----- rtl/baro_temp_pressure_compensation_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the barometric compensation block
// Shared by the port checker.
// ----------------------------------------------------------------------------
`ifndef BARO_TEMP_PRESSURE_COMPENSATION_MACROS_SVH
`define BARO_TEMP_PRESSURE_COMPENSATION_MACROS_SVH

// implication, disabled in reset
`define BTPC_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication, live through reset
`define BTPC_ASSERT_NEXT(label, clk, ante, cons) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ----- rtl/baro_tpc_pkg.sv -----
// ----------------------------------------------------------------------------
// baro_tpc_pkg
// Types, constants and arithmetic helpers for the compensation pipeline.
// ----------------------------------------------------------------------------
package baro_tpc_pkg;

    localparam int DIV_STAGES = 64;
    localparam int LATENCY    = 79;

    localparam logic [1:0] REG_TEMP_CAL   = 2'd0;
    localparam logic [1:0] REG_PRES_CAL_A = 2'd1;
    localparam logic [1:0] REG_PRES_CAL_B = 2'd2;
    localparam logic [1:0] REG_PRES_CAL_C = 2'd3;

    localparam logic [63:0]        FINE_OFFSET = 64'd128000;
    localparam logic [63:0]        P_BASE      = 64'd1048576;
    localparam logic [63:0]        V1_BIAS     = 64'h0000_8000_0000_0000;
    localparam logic signed [16:0] NUM_SCALE   = 17'sd3125;

    typedef struct packed {
        logic [31:0] temp;
        logic [31:0] fine;
    } t_side;

    function automatic logic signed [16:0] sx16(input logic [15:0] v);
        return {v[15], v};
    endfunction

    // a * b mod 2^64, b a 17-bit signed factor; two partial products
    function automatic logic [63:0] mul_s17(input logic [63:0] a,
                                            input logic signed [16:0] b);
        logic signed [32:0] al;
        logic signed [31:0] ah;
        logic signed [49:0] pl;
        logic signed [48:0] ph;
        al = {1'b0, a[31:0]};
        ah = a[63:32];
        pl = al * b;
        ph = ah * b;
        return 64'(pl) + {ph[31:0], 32'b0};
    endfunction

    // a * a mod 2^64
    function automatic logic [63:0] sq64(input logic [63:0] a);
        logic [31:0] al;
        logic [31:0] ah;
        logic [63:0] lo;
        logic [63:0] cr;
        al = a[31:0];
        ah = a[63:32];
        lo = al * al;
        cr = al * ah;
        return lo + {cr[30:0], 33'b0};
    endfunction

endpackage

// ----- rtl/baro_temp_pressure_compensation.sv -----
// Each accepted request leads to its own o_done strobe.
// Throughput: one request per cycle; busy is never raised.
// The divider has 64 stages, one quotient bit per stage.
// Reset (synchronous, active low) clears all valid bits and the calibration
// registers; results in flight are dropped. The receiver cannot stall.
// ----------------------------------------------------------------------------
// baro_temp_pressure_compensation
// Integer temperature and pressure compensation of raw barometer samples.
// ----------------------------------------------------------------------------
module baro_temp_pressure_compensation (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_idx,
    input  logic [63:0]        i_cfg_wdata,
    input  logic [19:0]        i_raw_temperature,
    input  logic [19:0]        i_raw_pressure,
    output logic               o_done,
    output logic signed [31:0] o_temperature,
    output logic signed [31:0] o_fine_temperature,
    output logic [31:0]        o_pressure,
    output logic               o_divisor_zero
);

    logic [47:0] r_temp_cal;
    logic [63:0] r_pres_cal_a;
    logic [63:0] r_pres_cal_b;
    logic [15:0] r_pres_cal_c;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_temp_cal   <= '0;
            r_pres_cal_a <= '0;
            r_pres_cal_b <= '0;
            r_pres_cal_c <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                baro_tpc_pkg::REG_TEMP_CAL:   r_temp_cal   <= i_cfg_wdata[47:0];
                baro_tpc_pkg::REG_PRES_CAL_A: r_pres_cal_a <= i_cfg_wdata;
                baro_tpc_pkg::REG_PRES_CAL_B: r_pres_cal_b <= i_cfg_wdata;
                baro_tpc_pkg::REG_PRES_CAL_C: r_pres_cal_c <= i_cfg_wdata[15:0];
                default: begin
                end
            endcase
        end
    end

    assign busy = 1'b0;

    logic [8:0] r_vld;
    logic [3:0] r_dvld;

    // ---- stage 1: temperature products
    logic        [31:0] n_x1;
    logic        [31:0] n_d;
    logic signed [47:0] n_aprod;
    logic        [63:0] n_dd;
    logic        [31:0] r_aprod;
    logic        [31:0] r_dd;
    logic        [19:0] r_adc_p1;

    assign n_x1    = {15'b0, i_raw_temperature[19:3]} - {15'b0, r_temp_cal[15:0], 1'b0};
    assign n_d     = {16'b0, i_raw_temperature[19:4]} - {16'b0, r_temp_cal[15:0]};
    assign n_aprod = $signed(n_x1) * $signed(r_temp_cal[31:16]);
    assign n_dd    = n_d * n_d;

    // ---- stage 2
    logic signed [31:0] n_a;
    logic signed [31:0] n_ds;
    logic signed [47:0] n_bprod;
    logic        [31:0] r_a;
    logic        [31:0] r_bprod;
    logic        [19:0] r_adc_p2;

    assign n_a     = $signed(r_aprod) >>> 11;
    assign n_ds    = $signed(r_dd) >>> 12;
    assign n_bprod = n_ds * $signed(r_temp_cal[47:32]);

    // ---- stage 3: fine term
    logic signed [31:0] n_bsh;
    logic        [31:0] r_fine3;
    logic        [19:0] r_adc_p3;

    assign n_bsh = $signed(r_bprod) >>> 14;

    // ---- stage 4: temperature, pressure offset
    logic        [31:0] n_f5;
    logic signed [31:0] n_temp;
    logic        [63:0] r_v1;
    logic        [19:0] r_adc_p4;

    assign n_f5   = {r_fine3[29:0], 2'b0} + r_fine3 + 32'd128;
    assign n_temp = $signed(n_f5) >>> 8;

    baro_tpc_pkg::t_side r_side [4:9];

    // ---- stages 5..9: pressure terms
    logic        [63:0] r_sq;
    logic        [63:0] r_m5;
    logic        [63:0] r_m2;
    logic        [63:0] r_v2a;
    logic        [63:0] r_v1b;
    logic        [63:0] r_m5b;
    logic        [63:0] r_m2b;
    logic        [63:0] r_v2;
    logic        [63:0] r_var;
    logic        [63:0] r_pp;
    logic        [63:0] r_n0;
    logic        [63:0] r_den;
    logic        [63:0] r_num;
    logic        [19:0] r_adc_p5;
    logic        [19:0] r_adc_p6;
    logic        [19:0] r_adc_p7;
    logic signed [63:0] n_v1bs;
    logic signed [63:0] n_den;

    assign n_v1bs = $signed(r_v1b) >>> 8;
    assign n_den  = $signed(r_pp) >>> 33;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[7:0], start & ~busy};
        end
    end

    always_ff @(posedge i_clk) begin
        r_aprod  <= n_aprod[31:0];
        r_dd     <= n_dd[31:0];
        r_adc_p1 <= i_raw_pressure;

        r_a      <= n_a;
        r_bprod  <= n_bprod[31:0];
        r_adc_p2 <= r_adc_p1;

        r_fine3  <= r_a + n_bsh;
        r_adc_p3 <= r_adc_p2;

        r_side[4].temp <= n_temp;
        r_side[4].fine <= r_fine3;
        r_v1     <= {{32{r_fine3[31]}}, r_fine3} - baro_tpc_pkg::FINE_OFFSET;
        r_adc_p4 <= r_adc_p3;

        r_sq     <= baro_tpc_pkg::sq64(r_v1);
        r_m5     <= baro_tpc_pkg::mul_s17(r_v1, baro_tpc_pkg::sx16(r_pres_cal_b[15:0]));
        r_m2     <= baro_tpc_pkg::mul_s17(r_v1, baro_tpc_pkg::sx16(r_pres_cal_a[31:16]));
        r_adc_p5 <= r_adc_p4;
        r_side[5] <= r_side[4];

        r_v2a    <= baro_tpc_pkg::mul_s17(r_sq, baro_tpc_pkg::sx16(r_pres_cal_b[31:16]));
        r_v1b    <= baro_tpc_pkg::mul_s17(r_sq, baro_tpc_pkg::sx16(r_pres_cal_a[47:32]));
        r_m5b    <= r_m5;
        r_m2b    <= r_m2;
        r_adc_p6 <= r_adc_p5;
        r_side[6] <= r_side[5];

        r_v2     <= r_v2a + (r_m5b << 17)
                    + ({{48{r_pres_cal_a[63]}}, r_pres_cal_a[63:48]} << 35);
        r_var    <= n_v1bs + (r_m2b << 12);
        r_adc_p7 <= r_adc_p6;
        r_side[7] <= r_side[6];

        r_pp     <= baro_tpc_pkg::mul_s17(baro_tpc_pkg::V1_BIAS + r_var,
                                          {1'b0, r_pres_cal_a[15:0]});
        r_n0     <= ((baro_tpc_pkg::P_BASE - {44'b0, r_adc_p7}) << 31) - r_v2;
        r_side[8] <= r_side[7];

        r_den    <= n_den;
        r_num    <= baro_tpc_pkg::mul_s17(r_n0, baro_tpc_pkg::NUM_SCALE);
        r_side[9] <= r_side[8];
    end

    // ---- divider
    logic                div_vld;
    logic [63:0]         div_quo;
    logic                div_dz;
    baro_tpc_pkg::t_side div_side;

    baro_tpc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_vld[8]),
        .i_num   (r_num),
        .i_den   (r_den),
        .i_side  (r_side[9]),
        .o_valid (div_vld),
        .o_quo   (div_quo),
        .o_dz    (div_dz),
        .o_side  (div_side)
    );

    // ---- final correction
    logic signed [63:0]  n_q13;
    logic signed [63:0]  n_c1s;
    logic signed [63:0]  n_c2s;
    logic signed [63:0]  n_ssh;
    logic        [31:0]  n_pres;
    logic        [63:0]  r_p_d1;
    logic        [63:0]  r_qsq;
    logic        [63:0]  r_c2m;
    logic        [63:0]  r_p_d2;
    logic        [63:0]  r_c1m;
    logic        [63:0]  r_c2m_d2;
    logic        [63:0]  r_s;
    logic                r_dz [1:3];
    baro_tpc_pkg::t_side r_dside [1:3];
    logic        [31:0]  r_temp_o;
    logic        [31:0]  r_fine_o;
    logic        [31:0]  r_pres_o;
    logic                r_dz_o;

    assign n_q13  = $signed(div_quo) >>> 13;
    assign n_c1s  = $signed(r_c1m) >>> 25;
    assign n_c2s  = $signed(r_c2m_d2) >>> 19;
    assign n_ssh  = $signed(r_s) >>> 8;
    assign n_pres = n_ssh[31:0] + {r_pres_cal_b[43:32], 4'b0, 16'b0} + 32'd0
                    + {{12{r_pres_cal_b[47]}}, r_pres_cal_b[47:32], 4'b0}
                    - {r_pres_cal_b[43:32], 4'b0, 16'b0};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dvld <= '0;
        end else begin
            r_dvld <= {r_dvld[2:0], div_vld};
        end
    end

    always_ff @(posedge i_clk) begin
        r_p_d1     <= div_quo;
        r_qsq      <= baro_tpc_pkg::sq64(n_q13);
        r_c2m      <= baro_tpc_pkg::mul_s17(div_quo, baro_tpc_pkg::sx16(r_pres_cal_b[63:48]));
        r_dz[1]    <= div_dz;
        r_dside[1] <= div_side;

        r_c1m      <= baro_tpc_pkg::mul_s17(r_qsq, baro_tpc_pkg::sx16(r_pres_cal_c));
        r_p_d2     <= r_p_d1;
        r_c2m_d2   <= r_c2m;
        r_dz[2]    <= r_dz[1];
        r_dside[2] <= r_dside[1];

        r_s        <= r_p_d2 + n_c1s + n_c2s;
        r_dz[3]    <= r_dz[2];
        r_dside[3] <= r_dside[2];

        r_pres_o   <= r_dz[3] ? 32'd0 : n_pres;
        r_dz_o     <= r_dz[3];
        r_temp_o   <= r_dside[3].temp;
        r_fine_o   <= r_dside[3].fine;
    end

    assign o_done             = r_dvld[3];
    assign o_temperature      = r_temp_o;
    assign o_fine_temperature = r_fine_o;
    assign o_pressure         = r_pres_o;
    assign o_divisor_zero     = r_dz_o;

endmodule

// ----- rtl/baro_tpc_div.sv -----
// ----------------------------------------------------------------------------
// baro_tpc_div
// Pipelined signed 64-bit truncating divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
module baro_tpc_div (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    input  logic [63:0]          i_num,
    input  logic [63:0]          i_den,
    input  baro_tpc_pkg::t_side  i_side,
    output logic                 o_valid,
    output logic [63:0]          o_quo,
    output logic                 o_dz,
    output baro_tpc_pkg::t_side  o_side
);

    localparam int N = baro_tpc_pkg::DIV_STAGES;

    logic [N:0]          r_vld;
    logic [63:0]         r_rem  [0:N];
    logic [63:0]         r_nq   [0:N];
    logic [63:0]         r_den  [0:N];
    logic                r_neg  [0:N];
    logic                r_dz   [0:N];
    baro_tpc_pkg::t_side r_side [0:N];
    logic                r_ovld;
    logic [63:0]         r_quo;
    logic                r_odz;
    baro_tpc_pkg::t_side r_oside;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld  <= '0;
            r_ovld <= 1'b0;
        end else begin
            r_vld  <= {r_vld[N-1:0], i_valid};
            r_ovld <= r_vld[N];
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem[0]  <= '0;
        r_nq[0]   <= i_num[63] ? (64'd0 - i_num) : i_num;
        r_den[0]  <= i_den[63] ? (64'd0 - i_den) : i_den;
        r_neg[0]  <= i_num[63] ^ i_den[63];
        r_dz[0]   <= (i_den == 64'd0);
        r_side[0] <= i_side;
    end

    for (genvar k = 1; k <= N; k++) begin : g_stage
        logic [64:0] n_sh;
        logic [64:0] n_diff;
        assign n_sh   = {r_rem[k-1], r_nq[k-1][63]};
        assign n_diff = n_sh - {1'b0, r_den[k-1]};
        always_ff @(posedge i_clk) begin
            r_rem[k]  <= n_diff[64] ? n_sh[63:0] : n_diff[63:0];
            r_nq[k]   <= {r_nq[k-1][62:0], ~n_diff[64]};
            r_den[k]  <= r_den[k-1];
            r_neg[k]  <= r_neg[k-1];
            r_dz[k]   <= r_dz[k-1];
            r_side[k] <= r_side[k-1];
        end
    end

    always_ff @(posedge i_clk) begin
        r_quo   <= r_neg[N] ? (64'd0 - r_nq[N]) : r_nq[N];
        r_odz   <= r_dz[N];
        r_oside <= r_side[N];
    end

    assign o_valid = r_ovld;
    assign o_quo   = r_quo;
    assign o_dz    = r_odz;
    assign o_side  = r_oside;

endmodule

// ----- rtl/baro_tpc_checker.sv -----
// ----------------------------------------------------------------------------
// baro_tpc_checker
// Port-level checks of the compensation block, bound to its top level.
// ----------------------------------------------------------------------------
`include "baro_temp_pressure_compensation_macros.svh"

module baro_tpc_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               start,
    input logic               busy,
    input logic               o_done,
    input logic [31:0]        o_pressure,
    input logic               o_divisor_zero
);

    `BTPC_ASSERT_IMPL(a_never_busy, i_clk, i_rst_n, 1'b1, !busy)
    `BTPC_ASSERT_IMPL(a_done_has_request, i_clk, i_rst_n, o_done, $past(start, baro_tpc_pkg::LATENCY))
    `BTPC_ASSERT_IMPL(a_dz_zero_pres, i_clk, i_rst_n, o_done && o_divisor_zero, o_pressure == 32'd0)
    `BTPC_ASSERT_NEXT(a_reset_quiet, i_clk, !i_rst_n, !o_done)

endmodule

bind baro_temp_pressure_compensation baro_tpc_checker u_baro_tpc_checker (.*);
